### hdl/nalsp_pkg.sv
// ----------------------------------------------------------------------------
// nalsp_pkg
// Beat types, constants and the result builder for the Annex B NAL splitter.
// ----------------------------------------------------------------------------
package nalsp_pkg;

    localparam logic [7:0]  BYTE_ZERO    = 8'h00;
    localparam logic [7:0]  BYTE_ONE     = 8'h01;
    localparam logic [2:0]  PREFIX_SHORT = 3'd3;
    localparam logic [2:0]  PREFIX_LONG  = 3'd4;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;
    localparam logic [23:0] WINDOW_EMPTY = 24'hFFFFFF;
    localparam logic [1:0]  FILL_FULL    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] unit_length;
        logic [2:0]  prefix_size;
        logic        length_saturated;
        logic        ended_by_buffer_end;
        logic        last_of_run;
    } t_out_beat;

    // results produced by one input byte, in delivery order
    typedef struct packed {
        logic [1:0] num;
        t_out_beat  first;
        t_out_beat  second;
    } t_scan_res;

    function automatic t_out_beat make_result(
        input logic [15:0] count,
        input logic        ovf,
        input logic [1:0]  extra,
        input logic [2:0]  prefix,
        input logic        by_end,
        input logic        last
    );
        logic [16:0] total;
        logic        sat;
        t_out_beat   res;
        total = {1'b0, count} + {15'b0, extra};
        sat   = ovf || total[16];
        res.unit_length         = sat ? LEN_MAX : total[15:0];
        res.prefix_size         = prefix;
        res.length_saturated    = sat;
        res.ended_by_buffer_end = by_end;
        res.last_of_run         = last;
        return res;
    endfunction

endpackage

### hdl/nalsp_scan.sv
// ----------------------------------------------------------------------------
// nalsp_scan
// Start code detection and unit length tracking, one byte per accepted beat.
// ----------------------------------------------------------------------------
module nalsp_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  nalsp_pkg::t_in_beat i_beat,
    output nalsp_pkg::t_scan_res o_res
);
    import nalsp_pkg::*;

    logic [23:0] r_window, n_window, s_window;
    logic [1:0]  r_fill,   n_fill,   s_fill;
    logic        r_inside, n_inside, s_inside;
    logic [15:0] r_count,  n_count,  s_count;
    logic        r_ovf,    n_ovf,    s_ovf;
    logic [2:0]  r_prefix, n_prefix, s_prefix;

    logic        start3;
    logic [2:0]  pfx;
    logic [1:0]  old_extra;
    logic        emit_old, emit_end;
    t_out_beat   res_old, res_end;
    t_scan_res   n_res;

    always_comb begin
        start3 = (i_beat.data_byte == BYTE_ONE) && (r_fill >= 2'd2)
                 && (r_window[15:0] == {BYTE_ZERO, BYTE_ZERO});
        pfx = ((r_fill == FILL_FULL) && (r_window[23:16] == BYTE_ZERO))
              ? PREFIX_LONG : PREFIX_SHORT;
        // window bytes not swallowed by the new prefix stay in the old unit
        old_extra = (pfx == PREFIX_LONG) ? r_fill - 2'd3 : r_fill - 2'd2;

        s_window = r_window;
        s_fill   = r_fill;
        s_inside = r_inside;
        s_count  = r_count;
        s_ovf    = r_ovf;
        s_prefix = r_prefix;
        if (start3) begin
            s_inside = 1'b1;
            s_prefix = pfx;
            s_count  = {13'b0, pfx};
            s_ovf    = 1'b0;
            s_window = WINDOW_EMPTY;
            s_fill   = 2'd0;
        end else begin
            if ((r_fill == FILL_FULL) && r_inside) begin
                if (r_count == LEN_MAX) begin
                    s_ovf = 1'b1;
                end else begin
                    s_count = r_count + 16'd1;
                end
            end
            s_window = {r_window[15:0], i_beat.data_byte};
            s_fill   = (r_fill == FILL_FULL) ? FILL_FULL : r_fill + 2'd1;
        end

        emit_old = start3 && r_inside;
        emit_end = i_beat.end_of_buffer && s_inside;

        res_old = make_result(r_count, r_ovf, old_extra, r_prefix, 1'b0, !emit_end);
        res_end = make_result(s_count, s_ovf, s_fill, s_prefix, 1'b1, 1'b1);

        n_res.num    = {1'b0, emit_old} + {1'b0, emit_end};
        n_res.first  = emit_old ? res_old : res_end;
        n_res.second = res_end;

        if (i_beat.end_of_buffer) begin
            n_window = WINDOW_EMPTY;
            n_fill   = 2'd0;
            n_inside = 1'b0;
            n_count  = 16'd0;
            n_ovf    = 1'b0;
            n_prefix = PREFIX_SHORT;
        end else begin
            n_window = s_window;
            n_fill   = s_fill;
            n_inside = s_inside;
            n_count  = s_count;
            n_ovf    = s_ovf;
            n_prefix = s_prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_EMPTY;
            r_fill   <= 2'd0;
            r_inside <= 1'b0;
            r_count  <= 16'd0;
            r_ovf    <= 1'b0;
            r_prefix <= PREFIX_SHORT;
        end else if (i_accept) begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_inside <= n_inside;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_prefix <= n_prefix;
        end
    end

    always_comb begin
        o_res = n_res;
        if (!i_accept) begin
            o_res.num = 2'd0;
        end
    end

endmodule

### hdl/nalsp_outq.sv
// ----------------------------------------------------------------------------
// nalsp_outq
// Result queue: takes up to two results per cycle, delivers one per beat.
// ----------------------------------------------------------------------------
module nalsp_outq #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nalsp_pkg::t_scan_res i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_stall,
    output nalsp_pkg::t_out_beat o_data
);
    import nalsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    t_out_beat     r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, wr_next;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          pop;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        pop     = o_valid && !i_stall;
        wr_next = wrap_inc(r_wr);
        unique case (i_push.num)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = wrap_inc(wr_next);
            default: n_wr = r_wr;
        endcase
        n_rd  = pop ? wrap_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CW'(i_push.num) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_room  = (r_cnt <= ROOM_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

### hdl/annexb_nal_unit_splitter_top.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_top
// H.264 Annex B start code splitter: one stream byte in, unit reports out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock unless stalled. Each accepted byte
// updates the start code window and unit counters in that same cycle and
// writes zero, one or two unit reports into a small output queue, where a
// report is registered before it is output. Input stalls only while the queue
// has fewer than two free entries, so sustained rate is one byte per cycle
// as long as the output side keeps taking reports. Reset is a single cycle.
module annexb_nal_unit_splitter_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  nalsp_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output nalsp_pkg::t_out_beat o_out_data
);
    import nalsp_pkg::*;

    logic      room;
    logic      accept;
    t_scan_res scan_res;

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    nalsp_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_data),
        .o_res    (scan_res)
    );

    nalsp_outq #(
        .DEPTH (FIFO_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

### hdl/nalsp_checker.sv
// ----------------------------------------------------------------------------
// nalsp_checker
// Port level checks for the Annex B NAL splitter, bound to the top level.
// ----------------------------------------------------------------------------
module nalsp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input nalsp_pkg::t_in_beat  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input nalsp_pkg::t_out_beat o_out_data
);
    import nalsp_pkg::*;

    // queue comes up empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input beat changed");

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.prefix_size == PREFIX_SHORT ||
                         o_out_data.prefix_size == PREFIX_LONG))
        else $error("bad prefix size");

    a_sat_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.length_saturated |->
            o_out_data.unit_length == LEN_MAX)
        else $error("saturated length not at max");

endmodule

bind annexb_nal_unit_splitter_top nalsp_checker u_nalsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
